// ===== hw/rtl/sdgp_pkg.sv =====
package sdgp_pkg;

  localparam int MAG_W   = 32;
  localparam int MAX_BCD = 10;
  localparam int BIT_CNT_W = $clog2(MAG_W + 1);

  localparam logic [5:0] MINUS_CODE   = 6'd45;
  localparam logic [5:0] DIGIT_BASE   = 6'd48;
  localparam logic [7:0] COLUMN_LIMIT = 8'd126;

  typedef struct packed {
    logic signed [31:0] value;
    logic [7:0]         start_column;
    logic [2:0]         start_page;
  } in_t;

  typedef struct packed {
    logic [5:0] char_code;
    logic [7:0] column;
    logic [3:0] page;
    logic       last;
  } out_t;

  // one character handed to the output stage, before placement
  typedef struct packed {
    logic [5:0] code;
    logic [7:0] col;
    logic [2:0] page;
    logic       last;
  } place_req_t;

endpackage

// ===== hw/rtl/sdgp_bcd.sv =====
module sdgp_bcd
  import sdgp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [MAG_W-1:0]       mag,
  output logic                   done,
  output logic [4*MAX_BCD-1:0]   bcd
);

  logic [MAG_W-1:0]     sh;
  logic [BIT_CNT_W-1:0] bits;
  logic                 busy;
  logic [4*MAX_BCD-1:0] bcd_adj;

  // add 3 to every digit that will reach 10 or more after the shift
  always_comb begin
    for (int i = 0; i < MAX_BCD; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bits <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bits <= BIT_CNT_W'(MAG_W);
      end else if (busy) begin
        bits <= bits - BIT_CNT_W'(1);
        if (bits == BIT_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= mag;
      bcd <= '0;
    end else if (busy) begin
      sh  <= sh << 1;
      bcd <= {bcd_adj[4*MAX_BCD-2:0], sh[MAG_W-1]};
    end
  end

endmodule

// ===== hw/rtl/sdgp_place.sv =====
module sdgp_place
  import sdgp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  place_req_t req,
  output logic       free,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // past the right edge the character moves to column 0 of the next page
  always_ff @(posedge clk) begin
    if (load) begin
      out_data.char_code <= req.code;
      out_data.last      <= req.last;
      if (req.col > COLUMN_LIMIT) begin
        out_data.column <= '0;
        out_data.page   <= {1'b0, req.page} + 4'd1;
      end else begin
        out_data.column <= req.col;
        out_data.page   <= {1'b0, req.page};
      end
    end
  end

endmodule

// ===== hw/rtl/signed_decimal_glyph_placer_top.sv =====
// sequence: an accepted request is converted by a bit-serial binary-to-bcd shift of the
// magnitude; then a minus sign is placed for a negative value, leading zeros are skipped
// and the remaining digits are placed one character at a time, an output stall holding the sign or digit
// stage; a magnitude too large for MAX_DIGITS places only the minus sign, if negative, and no digits;
// a new request is accepted only once the sequencer is back in idle after the previous one
// reset: synchronous, clears the sequencer, converter and output valid
module signed_decimal_glyph_placer_top
  import sdgp_pkg::*;
#(
  parameter int MAX_DIGITS = 8,
  parameter int CHAR_WIDTH = 6
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_SIGN  = 3'd2;
  localparam logic [2:0] S_SKIP  = 3'd3;
  localparam logic [2:0] S_DIGIT = 3'd4;

  logic [2:0]              state;
  logic                    neg;
  logic                    too_large;
  logic [7:0]              col;
  logic [2:0]              page;
  logic [4*MAX_DIGITS-1:0] dig;
  logic [CNT_W-1:0]        cnt;

  logic                 accept;
  logic [MAG_W-1:0]     mag;
  logic                 conv_done;
  logic [4*MAX_BCD-1:0] bcd;
  logic                 over;
  logic [3:0]           top_digit;
  logic                 free;
  logic                 load;
  place_req_t           req;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign mag       = in_data.value[MAG_W-1] ? (~MAG_W'(in_data.value) + MAG_W'(1))
                                            : MAG_W'(in_data.value);
  assign top_digit = dig[4*MAX_DIGITS-1 -: 4];

  // any nonzero digit beyond the display width makes the magnitude too large
  always_comb begin
    over = 1'b0;
    for (int i = MAX_DIGITS; i < MAX_BCD; i++) begin
      over = over | (bcd[4*i +: 4] != 4'd0);
    end
  end

  sdgp_bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .mag   (mag),
    .done  (conv_done),
    .bcd   (bcd)
  );

  always_comb begin
    load      = 1'b0;
    req.code  = MINUS_CODE;
    req.col   = col;
    req.page  = page;
    req.last  = too_large;
    unique case (state)
      S_SIGN: begin
        load = free;
      end
      S_DIGIT: begin
        load     = free;
        req.code = DIGIT_BASE + {2'b00, top_digit};
        req.last = (cnt == CNT_W'(1));
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  sdgp_place u_place (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .req       (req),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (conv_done) begin
            if (neg) begin
              state <= S_SIGN;
            end else if (over) begin
              state <= S_IDLE;
            end else begin
              state <= S_SKIP;
            end
          end
        end
        S_SIGN: begin
          if (free) begin
            state <= too_large ? S_IDLE : S_SKIP;
          end
        end
        S_SKIP: begin
          if (top_digit != 4'd0 || cnt == CNT_W'(1)) begin
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (free && cnt == CNT_W'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg  <= in_data.value[MAG_W-1];
      col  <= in_data.start_column;
      page <= in_data.start_page;
    end
    if (state == S_CONV && conv_done) begin
      too_large <= over;
      dig       <= bcd[4*MAX_DIGITS-1:0];
      cnt       <= CNT_W'(MAX_DIGITS);
    end
    // drop leading zeros, keeping at least one digit
    if (state == S_SKIP && top_digit == 4'd0 && cnt != CNT_W'(1)) begin
      dig <= dig << 4;
      cnt <= cnt - CNT_W'(1);
    end
    if (load) begin
      col <= col + 8'(CHAR_WIDTH);
      if (state == S_DIGIT) begin
        dig <= dig << 4;
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

endmodule
